// ===== src/qfa_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: opcodes, payload structs and defaults.
package qfa_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int PORT_WIDTH     = 32;

   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_SUB      = 4'd1;
   localparam logic [3:0] OP_MUL      = 4'd2;
   localparam logic [3:0] OP_DIV      = 4'd3;
   localparam logic [3:0] OP_GT       = 4'd4;
   localparam logic [3:0] OP_LT       = 4'd5;
   localparam logic [3:0] OP_GE       = 4'd6;
   localparam logic [3:0] OP_LE       = 4'd7;
   localparam logic [3:0] OP_EQ       = 4'd8;
   localparam logic [3:0] OP_NE       = 4'd9;
   localparam logic [3:0] OP_MIN      = 4'd10;
   localparam logic [3:0] OP_MAX      = 4'd11;
   localparam logic [3:0] OP_INC      = 4'd12;
   localparam logic [3:0] OP_DEC      = 4'd13;
   localparam logic [3:0] OP_TO_INT   = 4'd14;
   localparam logic [3:0] OP_FROM_INT = 4'd15;

   typedef struct packed {
      logic [3:0]               mode;
      logic signed [PORT_WIDTH-1:0] operand_a;
      logic signed [PORT_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [PORT_WIDTH-1:0] result_value;
      logic                         compare_true;
      logic                         divide_by_zero;
   } rsp_type;

   // Side data that rides along the divider stages.
   typedef struct packed {
      logic signed [PORT_WIDTH-1:0] res_value;
      logic                         compare_true;
      logic                         divide_by_zero;
      logic                         neg;
      logic                         is_mul;
      logic                         is_div;
   } side_type;

endpackage

// ===== src/qfa_front.sv =====
// Front stage: operand decode, multiplier, simple ops and divider setup.
module qfa_front #(
   parameter int FRAC_BITS  = qfa_pkg::FRAC_BITS_DEF,
   parameter int DATA_WIDTH = qfa_pkg::DATA_WIDTH_DEF,
   parameter int QW         = DATA_WIDTH + FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  qfa_pkg::req_type             req,
   output logic                         valid_ff,
   output qfa_pkg::side_type            side_ff,
   output logic signed [2*DATA_WIDTH-1:0] product_ff,
   output logic [QW-1:0]                dividend_ff,
   output logic [DATA_WIDTH-1:0]        divisor_ff
);

   logic signed [DATA_WIDTH-1:0]   a, b, simple;
   logic [DATA_WIDTH-1:0]          a_mag, b_mag;
   logic                           cmp;
   qfa_pkg::side_type              side_in;

   assign a = signed'(req.operand_a[DATA_WIDTH-1:0]);
   assign b = signed'(req.operand_b[DATA_WIDTH-1:0]);
   assign a_mag = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
   assign b_mag = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);

   always_comb begin
      simple = '0;
      cmp    = 1'b0;
      unique case (req.mode)
         qfa_pkg::OP_ADD:      simple = DATA_WIDTH'(a + b);
         qfa_pkg::OP_SUB:      simple = DATA_WIDTH'(a - b);
         qfa_pkg::OP_GT:       cmp = (a > b);
         qfa_pkg::OP_LT:       cmp = (a < b);
         qfa_pkg::OP_GE:       cmp = (a >= b);
         qfa_pkg::OP_LE:       cmp = (a <= b);
         qfa_pkg::OP_EQ:       cmp = (a == b);
         qfa_pkg::OP_NE:       cmp = (a != b);
         qfa_pkg::OP_MIN:      simple = (a < b) ? a : b;
         qfa_pkg::OP_MAX:      simple = (a > b) ? a : b;
         qfa_pkg::OP_INC:      simple = DATA_WIDTH'(a + 1);
         qfa_pkg::OP_DEC:      simple = DATA_WIDTH'(a - 1);
         qfa_pkg::OP_TO_INT:   simple = a >>> FRAC_BITS;
         qfa_pkg::OP_FROM_INT: simple = a <<< FRAC_BITS;
         default:              simple = '0;   // mul and div finish later
      endcase
   end

   always_comb begin
      side_in                = '0;
      side_in.res_value      = qfa_pkg::PORT_WIDTH'(simple);
      side_in.compare_true   = cmp;
      side_in.is_mul         = (req.mode == qfa_pkg::OP_MUL);
      side_in.is_div         = (req.mode == qfa_pkg::OP_DIV);
      side_in.divide_by_zero = side_in.is_div && (b == '0);
      side_in.neg            = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff     <= side_in;
      product_ff  <= a * b;
      dividend_ff <= {a_mag, {FRAC_BITS{1'b0}}};
      divisor_ff  <= b_mag;
   end

endmodule

// ===== src/qfa_div_step.sv =====
// One restoring-division stage: one quotient bit, registered.
module qfa_div_step #(
   parameter int DATA_WIDTH = qfa_pkg::DATA_WIDTH_DEF,
   parameter int QW         = DATA_WIDTH + qfa_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  qfa_pkg::side_type     in_side,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [QW-1:0]         in_dq,
   input  logic [DATA_WIDTH-1:0] in_d,
   output logic                  valid_ff,
   output qfa_pkg::side_type     side_ff,
   output logic [DATA_WIDTH-1:0] rem_ff,
   output logic [QW-1:0]         dq_ff,
   output logic [DATA_WIDTH-1:0] d_ff
);

   logic [DATA_WIDTH:0] trial, diff;
   logic                ge;

   assign trial = {in_rem, in_dq[QW-1]};
   assign diff  = trial - {1'b0, in_d};
   assign ge    = (trial >= {1'b0, in_d});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      rem_ff  <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      dq_ff   <= {in_dq[QW-2:0], ge};
      d_ff    <= in_d;
   end

endmodule

// ===== src/fixed_point_q24_8_alu_core.sv =====
// Top level of the pipelined Q24.8 fixed-point ALU.
//
// Usage:
//   Request channel: drive req_data and raise start; a transfer happens at
//   each rising edge with start high and busy low. busy is always low, so a
//   new request may be issued every cycle.
//   Response channel: rsp_valid pulses for one cycle with rsp_data; the
//   receiver must take it in that cycle (no backpressure exists).
// Pipeline: every opcode passes one front stage, one divider stage per
//   quotient bit and one output stage. All opcodes share the same path
//   so order is preserved.
// Throughput: one transfer per cycle; the bit-per-stage divider pipeline
//   sets the depth, not the rate.
// Reset: synchronous, clears all valid bits; items in flight are dropped.
//   Payload registers are not reset.
module fixed_point_q24_8_alu_core #(
   parameter int FRAC_BITS  = qfa_pkg::FRAC_BITS_DEF,
   parameter int DATA_WIDTH = qfa_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qfa_pkg::req_type req_data,
   output logic             rsp_valid,
   output qfa_pkg::rsp_type rsp_data
);

   localparam int QW      = DATA_WIDTH + FRAC_BITS;
   localparam int LATENCY = QW + 2;

   // Never stalls.
   assign busy = 1'b0;

   logic                           f_valid;
   qfa_pkg::side_type              f_side, s0_side;
   logic signed [2*DATA_WIDTH-1:0] f_product;
   logic [QW-1:0]                  f_dividend;
   logic [DATA_WIDTH-1:0]          f_divisor;
   logic signed [DATA_WIDTH-1:0]   mul_res;

   qfa_front #(
      .FRAC_BITS (FRAC_BITS),
      .DATA_WIDTH(DATA_WIDTH),
      .QW        (QW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .req        (req_data),
      .valid_ff   (f_valid),
      .side_ff    (f_side),
      .product_ff (f_product),
      .dividend_ff(f_dividend),
      .divisor_ff (f_divisor)
   );

   // Product >>> FRAC_BITS, kept to DATA_WIDTH bits.
   assign mul_res = DATA_WIDTH'(f_product >>> FRAC_BITS);

   always_comb begin
      s0_side = f_side;
      if (f_side.is_mul) begin
         s0_side.res_value = qfa_pkg::PORT_WIDTH'(mul_res);
      end
   end

   // Divider chain: stage k produces quotient bit QW-1-k.
   logic                  st_valid [QW+1];
   qfa_pkg::side_type     st_side  [QW+1];
   logic [DATA_WIDTH-1:0] st_rem   [QW+1];
   logic [QW-1:0]         st_dq    [QW+1];
   logic [DATA_WIDTH-1:0] st_d     [QW+1];

   assign st_valid[0] = f_valid;
   assign st_side[0]  = s0_side;
   assign st_rem[0]   = '0;
   assign st_dq[0]    = f_dividend;
   assign st_d[0]     = f_divisor;

   for (genvar k = 0; k < QW; k++) begin : g_div
      qfa_div_step #(
         .DATA_WIDTH(DATA_WIDTH),
         .QW        (QW)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .in_valid(st_valid[k]),
         .in_side (st_side[k]),
         .in_rem  (st_rem[k]),
         .in_dq   (st_dq[k]),
         .in_d    (st_d[k]),
         .valid_ff(st_valid[k+1]),
         .side_ff (st_side[k+1]),
         .rem_ff  (st_rem[k+1]),
         .dq_ff   (st_dq[k+1]),
         .d_ff    (st_d[k+1])
      );
   end

   // Output stage: sign the quotient, pick the result.
   qfa_pkg::side_type            l_side;
   logic [DATA_WIDTH-1:0]        q_mag;
   logic signed [DATA_WIDTH-1:0] q_signed;
   qfa_pkg::rsp_type             rsp_in;
   logic                         rsp_valid_ff;
   qfa_pkg::rsp_type             rsp_data_ff;

   assign l_side   = st_side[QW];
   assign q_mag    = st_dq[QW][DATA_WIDTH-1:0];
   assign q_signed = l_side.neg ? signed'(DATA_WIDTH'(-q_mag)) : signed'(q_mag);

   always_comb begin
      rsp_in.compare_true   = l_side.compare_true;
      rsp_in.divide_by_zero = l_side.divide_by_zero;
      if (l_side.is_div) begin
         rsp_in.result_value = l_side.divide_by_zero ? '0 :
                               qfa_pkg::PORT_WIDTH'(q_signed);
      end else begin
         rsp_in.result_value = l_side.res_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= st_valid[QW];
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Each transfer comes out after a fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("response missing after fixed latency");

   // Divide by zero gives zero and no compare flag.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_by_zero) |->
         (rsp_data.result_value == '0 && !rsp_data.compare_true))
      else $error("divide by zero result not clean");

   // Comparisons return a zero value.
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.compare_true) |-> (rsp_data.result_value == '0))
      else $error("comparison carries a nonzero value");

endmodule
